// ===== rtl/byte_pretoken_splitter_unit_defines.svh =====
// Assertion helpers shared by the splitter modules.
`ifndef BYTE_PRETOKEN_SPLITTER_UNIT_DEFINES_SVH
`define BYTE_PRETOKEN_SPLITTER_UNIT_DEFINES_SVH

// Check a condition on every clock edge out of reset.
`define BPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Check a consequence in the same cycle as its cause.
`define BPS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define BPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bps_pkg.sv =====
package bps_pkg;

	// Chunk classes as they appear on the chunk_class port
	typedef enum logic [2:0] {
		CLS_CONTRACT = 3'd0,
		CLS_LETTER   = 3'd1,
		CLS_DIGIT    = 3'd2,
		CLS_PUNCT    = 3'd3,
		CLS_SPACE    = 3'd4
	} chunk_class_t;

	// Characters the split rules look at
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] HIGH_LETTER = 8'h80;

	// Split state carried from one byte to the next
	typedef struct packed {
		logic         ab;   // next byte opens a chunk
		chunk_class_t cc;   // class of the open chunk
		logic         rlo;  // whitespace run already put out a byte
	} split_state_t;

	localparam split_state_t SPLIT_RESET = '{ab: 1'b1, cc: CLS_CONTRACT, rlo: 1'b0};

	// Outcome of deciding the chunk at one window position
	typedef struct packed {
		logic [1:0]   consumed;  // bytes settled, zero when waiting for more text
		logic         start;     // first settled byte opens a chunk
		chunk_class_t cls;
		split_state_t st;
	} decide_t;

	// One result word held in the queue
	typedef struct packed {
		logic [7:0]   data;
		logic         start;
		chunk_class_t cls;
		logic         last;
	} q_entry_t;

	// Up to three words pushed in one cycle
	typedef struct packed {
		logic [1:0]         n;
		q_entry_t [2:0]     ent;
	} q_push_t;

endpackage

// ===== rtl/bps_front.sv =====
`include "byte_pretoken_splitter_unit_defines.svh"

module bps_front import bps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  logic       room,
	output q_push_t    push
);

	// Sort a byte into its character class
	function automatic chunk_class_t classify(logic [7:0] b);
		chunk_class_t c;
		if (b inside {[8'h41:8'h5A], [8'h61:8'h7A]} || b >= HIGH_LETTER) begin
			c = CLS_LETTER;
		end else if (b inside {[8'h30:8'h39]}) begin
			c = CLS_DIGIT;
		end else if (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF}) begin
			c = CLS_SPACE;
		end else begin
			c = CLS_PUNCT;
		end
		return c;
	endfunction

	// Settle the chunk at one position: b0 is the byte, b1 and b2 follow it
	function automatic decide_t decide(split_state_t st, logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [1:0] rem, logic fin);
		decide_t      d;
		chunk_class_t cb;
		chunk_class_t cn;
		logic         done;
		logic         go_on;
		logic         hit;
		cb = classify(b0);
		cn = classify(b1);
		d.consumed = 2'd0;
		d.start = 1'b0;
		d.cls = st.cc;
		d.st = st;
		done = 1'b0;
		go_on = 1'b1;
		hit = (b1 == CH_L) ? (b2 == CH_L) : (b2 == CH_E);

		// continue an open chunk
		if (!st.ab) begin
			if ((st.cc == CLS_LETTER || st.cc == CLS_DIGIT || st.cc == CLS_PUNCT) &&
					cb == st.cc) begin
				d.consumed = 2'd1;
				done = 1'b1;
			end else if (st.cc == CLS_SPACE && cb == CLS_SPACE) begin
				if (rem >= 2'd2) begin
					if (cn == CLS_SPACE) begin
						d.consumed = 2'd1;
						d.cls = CLS_SPACE;
						d.st.rlo = 1'b1;
						done = 1'b1;
					end else if (st.rlo) begin
						// give up the last run byte to the next chunk
						d.st.ab = 1'b1;
						d.st.rlo = 1'b0;
					end else begin
						d.consumed = 2'd1;
						d.cls = CLS_SPACE;
						d.st.ab = 1'b1;
						done = 1'b1;
					end
				end else begin
					done = 1'b1;
					if (fin) begin
						d.consumed = 2'd1;
						d.cls = CLS_SPACE;
					end
				end
			end else begin
				d.st.ab = 1'b1;
				d.st.rlo = 1'b0;
			end
		end

		// open a new chunk
		if (!done) begin
			if (b0 == CH_QUOTE) begin
				if (rem >= 2'd2) begin
					if (b1 inside {CH_S, CH_T, CH_M, CH_D}) begin
						d.consumed = 2'd2;
						d.start = 1'b1;
						d.cls = CLS_CONTRACT;
						go_on = 1'b0;
					end else if (b1 inside {CH_R, CH_V, CH_L}) begin
						if (rem == 2'd3) begin
							if (hit) begin
								d.consumed = 2'd3;
								d.start = 1'b1;
								d.cls = CLS_CONTRACT;
								go_on = 1'b0;
							end
						end else if (!fin) begin
							go_on = 1'b0;
						end
					end
				end else if (!fin) begin
					go_on = 1'b0;
				end
			end
			if (go_on) begin
				if (cb != CLS_SPACE) begin
					d.consumed = 2'd1;
					d.start = 1'b1;
					d.cls = cb;
					d.st.cc = cb;
					d.st.ab = 1'b0;
				end else if (rem >= 2'd2) begin
					d.consumed = 2'd1;
					d.start = 1'b1;
					if (b0 == CH_SPACE && cn != CLS_SPACE) begin
						// leading space joins the chunk after it
						d.cls = cn;
						d.st.cc = cn;
						d.st.ab = 1'b0;
					end else if (cn == CLS_SPACE) begin
						d.cls = CLS_SPACE;
						d.st.cc = CLS_SPACE;
						d.st.ab = 1'b0;
						d.st.rlo = 1'b1;
					end else begin
						d.cls = CLS_SPACE;
						d.st.cc = CLS_SPACE;
					end
				end else if (fin) begin
					d.consumed = 2'd1;
					d.start = 1'b1;
					d.cls = CLS_SPACE;
					d.st.cc = CLS_SPACE;
				end
			end
		end
		return d;
	endfunction

	logic         accept;
	logic [7:0]   la_q [2];
	logic [1:0]   held_q;
	split_state_t st_q;

	logic [7:0]   bw [3];
	logic [7:0]   w0;
	logic [7:0]   w1;
	logic [7:0]   w2;
	logic [1:0]   n_w;
	logic [1:0]   pos_w;
	logic [1:0]   left_w;
	logic [1:0]   held_n;
	logic         halted;
	split_state_t st_w;
	decide_t      dec;
	logic [2:0]   start_w;
	chunk_class_t cls_w [3];
	logic [7:0]   la_n [2];

	// Take a byte whenever the queue has room for a full step
	assign text_stall = !room;
	assign accept = text_valid && !text_stall;

	// Line up held bytes and the new byte, then settle up to three chunk positions
	always_comb begin
		bw[0] = la_q[0];
		bw[1] = la_q[1];
		bw[2] = text_byte;
		case (held_q)
			2'd0: bw[0] = text_byte;
			2'd1: bw[1] = text_byte;
			default: ;
		endcase
		n_w = held_q + 2'd1;
		pos_w = 2'd0;
		halted = 1'b0;
		st_w = st_q;
		start_w = 3'b000;
		cls_w = '{default: CLS_CONTRACT};
		dec = '0;
		w0 = bw[0];
		w1 = bw[1];
		w2 = bw[2];
		for (int it = 0; it < 3; it++) begin
			case (pos_w)
				2'd0: begin
					w0 = bw[0];
					w1 = bw[1];
					w2 = bw[2];
				end
				2'd1: begin
					w0 = bw[1];
					w1 = bw[2];
					w2 = bw[2];
				end
				default: begin
					w0 = bw[2];
					w1 = bw[2];
					w2 = bw[2];
				end
			endcase
			if (!halted && pos_w < n_w) begin
				dec = decide(st_w, w0, w1, w2, n_w - pos_w, end_of_text);
				st_w = dec.st;
				for (int j = 0; j < 3; j++) begin
					if (2'(j) < dec.consumed) begin
						start_w[pos_w + 2'(j)] = dec.start && (j == 0);
						cls_w[pos_w + 2'(j)] = dec.cls;
					end
				end
				pos_w = pos_w + dec.consumed;
				if (dec.consumed == 2'd0) begin
					halted = 1'b1;
				end
			end
		end
	end

	// Keep the undecided tail as lookahead
	always_comb begin
		left_w = n_w - pos_w;
		held_n = (left_w > 2'd2) ? 2'd2 : left_w;
		case (pos_w)
			2'd0: begin
				la_n[0] = bw[0];
				la_n[1] = bw[1];
			end
			2'd1: begin
				la_n[0] = bw[1];
				la_n[1] = bw[2];
			end
			default: begin
				la_n[0] = bw[2];
				la_n[1] = bw[2];
			end
		endcase
	end

	// Push settled words, marking the last word of the text
	always_comb begin
		push.n = accept ? pos_w : 2'd0;
		for (int k = 0; k < 3; k++) begin
			push.ent[k].data = bw[k];
			push.ent[k].start = start_w[k];
			push.ent[k].cls = cls_w[k];
			push.ent[k].last = end_of_text && (2'(k) == pos_w - 2'd1);
		end
	end

	// Advance split state; drop back to reset state after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
			st_q <= SPLIT_RESET;
		end else if (accept) begin
			if (end_of_text) begin
				held_q <= 2'd0;
				st_q <= SPLIT_RESET;
			end else begin
				held_q <= held_n;
				st_q <= st_w;
			end
		end
	end

	// Hold lookahead bytes
	always_ff @(posedge clk) begin
		if (accept && !end_of_text) begin
			la_q[0] <= la_n[0];
			la_q[1] <= la_n[1];
		end
	end

	`BPS_ASSERT_ALWAYS(a_held_limit, clk, arst_n, held_q <= 2'd2, "lookahead holds more than two bytes")
	`BPS_ASSERT_IMPLIES(a_bnd_no_run, clk, arst_n, st_q.ab, !st_q.rlo, "run flag set at a chunk boundary")
	`BPS_ASSERT_NEXT(a_fin_clears, clk, arst_n, accept && end_of_text, held_q == 2'd0 && st_q.ab, "state not cleared after final byte")

endmodule

// ===== rtl/bps_queue.sv =====
`include "byte_pretoken_splitter_unit_defines.svh"

module bps_queue import bps_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  q_push_t    push,
	output logic       room,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       chunk_start,
	output logic [2:0] chunk_class,
	output logic       final_byte
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	q_entry_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	q_entry_t        head;

	// Room for a full three-word step
	assign room = count_q <= CW'(DEPTH - 3);

	assign result_valid = count_q != '0;
	assign pop = result_valid && !result_stall;

	// Present the head word
	assign head = mem_q[rd_q];
	assign out_byte = head.data;
	assign chunk_start = head.start;
	assign chunk_class = head.cls;
	assign final_byte = head.last;

	// Write pushed words at consecutive slots
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < push.n) begin
				mem_q[wr_q + AW'(k)] <= push.ent[k];
			end
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + AW'(push.n);
			rd_q <= rd_q + AW'(pop);
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

	`BPS_ASSERT_ALWAYS(a_count_limit, clk, arst_n, count_q <= CW'(DEPTH), "queue count above depth")
	`BPS_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push.n != 2'd0, (count_q + CW'(push.n)) <= CW'(DEPTH), "push overruns queue")
	`BPS_ASSERT_NEXT(a_count_track, clk, arst_n, 1'b1, count_q == $past(count_q) + CW'($past(push.n)) - CW'($past(pop)), "queue count out of step")

endmodule

// ===== rtl/byte_pretoken_splitter_unit.sv =====
// Byte pre-tokenizer splitter.
// Text channel: text_valid / text_stall carry one text byte per word, with
// end_of_text high on the last byte of a text. Result channel: result_valid /
// result_stall carry every byte again, in order, with chunk_start, chunk_class
// and final_byte (high on the last byte of the text).
// The front settles chunk boundaries with up to two bytes of lookahead and
// pushes zero to three words per accepted byte into a QUEUE_DEPTH-word queue;
// the back presents the queue head on the result ports.
// Throughput: one byte per cycle in both directions while neither side stalls,
// set by the single front step per cycle and one queue read per cycle.
// Latency: a byte whose chunk is decided on arrival appears on the result
// port the cycle after it is accepted when no older word waits in the queue;
// a byte held as lookahead waits for up to two more text bytes (a contraction
// prefix or a whitespace run), or for end_of_text.
// Stall: text_stall rises when the queue lacks room for three words; a stalled
// result holds its word, and the front keeps accepting until fewer than three
// queue slots are free.
// Reset: the queue empties and the split state returns to chunk start with no
// held bytes; the same state follows every final byte.
module byte_pretoken_splitter_unit import bps_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       chunk_start,
	output logic [2:0] chunk_class,
	output logic       final_byte
);

	q_push_t push;
	logic    room;

	// Accept and classify bytes
	bps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.room        (room),
		.push        (push)
	);

	// Queue words and deliver them
	bps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.chunk_start  (chunk_start),
		.chunk_class  (chunk_class),
		.final_byte   (final_byte)
	);

endmodule
